@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/fcf_pkg.sv @@
// ----------------------------------------------------------------------------
// fcf_pkg
// constants, types and arithmetic helpers of the file content fingerprint
// ----------------------------------------------------------------------------
`default_nettype none

package fcf_pkg;

  localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] GOLDEN       = 64'h9e3779b97f4a7c15;
  localparam logic [47:0] HEAD_LIMIT   = 48'd4194304;

  typedef struct packed {
    logic [63:0] head;
    logic [63:0] tail;
    logic [47:0] size;
  } fcf_final_t;

  // fnv-1a step, prime 2^40 + 0x1b3 as shifts and adds
  function automatic logic [63:0] fnv_byte(input logic [63:0] acc, input logic [7:0] b);
    logic [63:0] x;
    x = acc ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

  function automatic logic [63:0] mix_in(input logic [63:0] acc, input logic [63:0] v);
    return acc ^ (v + GOLDEN + (acc << 6) + (acc >> 2));
  endfunction

endpackage

`default_nettype wire

@@ rtl/fcf_hash.sv @@
// ----------------------------------------------------------------------------
// fcf_hash
// input register, head and tail fnv-1a accumulators, closing handoff register
// ----------------------------------------------------------------------------
`default_nettype none

module fcf_hash import fcf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        in_tail,
  input  wire logic        last,
  input  wire logic [47:0] file_size,
  output logic             fin_valid,
  input  wire logic        fin_ready,
  output fcf_final_t       fin
);

  logic        a_valid;
  logic [7:0]  a_byte;
  logic        a_has;
  logic        a_tail;
  logic        a_last;
  logic [47:0] a_size;
  logic [63:0] head_hash;
  logic [63:0] tail_hash;
  logic [63:0] head_next;
  logic [63:0] tail_next;
  logic        a_adv;

  assign a_adv    = a_valid && (!a_last || !fin_valid || fin_ready);
  assign in_ready = !a_valid || a_adv;

  assign head_next = (a_has && !a_tail) ? fnv_byte(head_hash, a_byte) : head_hash;
  assign tail_next = (a_has && a_tail)  ? fnv_byte(tail_hash, a_byte) : tail_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      fin_valid <= 1'b0;
      head_hash <= OFFSET_BASIS;
      tail_hash <= OFFSET_BASIS;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_adv && a_last) begin
        fin_valid <= 1'b1;
      end else if (fin_ready) begin
        fin_valid <= 1'b0;
      end
      if (a_adv) begin
        if (a_last) begin
          head_hash <= OFFSET_BASIS;
          tail_hash <= OFFSET_BASIS;
        end else begin
          head_hash <= head_next;
          tail_hash <= tail_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= data_byte;
      a_has  <= has_byte;
      a_tail <= in_tail;
      a_last <= last;
      a_size <= file_size;
    end
    if (a_adv && a_last) begin
      fin.head <= head_next;
      fin.tail <= tail_next;
      fin.size <= a_size;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fcf_mix.sv @@
// ----------------------------------------------------------------------------
// fcf_mix
// golden-ratio mix stage and the output register, which mixes in the size
// ----------------------------------------------------------------------------
`default_nettype none

module fcf_mix import fcf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fin_valid,
  output logic             fin_ready,
  input  wire fcf_final_t  fin,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_data
);

  logic        c_valid;
  logic [63:0] c_fp;
  logic [47:0] c_size;
  logic        c_adv;

  assign c_adv     = c_valid && (!out_valid || out_ready);
  assign fin_ready = !c_valid || c_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_ready) begin
        c_valid <= fin_valid;
      end
      if (c_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      c_fp   <= (fin.size > HEAD_LIMIT) ? mix_in(fin.head, fin.tail) : fin.head;
      c_size <= fin.size;
    end
    if (c_adv) begin
      out_data <= mix_in(c_fp, {16'd0, c_size});
    end
  end

endmodule

`default_nettype wire

@@ rtl/file_content_fingerprint.sv @@
// ----------------------------------------------------------------------------
// file_content_fingerprint
// fnv-1a 64-bit head and tail hashes of one file, closed into a fingerprint
// ----------------------------------------------------------------------------
// Takes one word per clock cycle, a content byte or a bare closing word, with
// no gap between files, while no closing word is held; the fnv-1a multiply
// of the head or tail accumulator is the loop that sets this rate. The word
// marked tlast gives one fingerprint word on the master side through the input,
// closing handoff, first mix and output registers; a stalled output holds back
// input only once a closing word waits behind full handoff and mix registers.
`default_nettype none

`include "assert_macros.svh"

module file_content_fingerprint import fcf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // data_byte[7:0], file_size[55:8]
  input  wire logic [1:0]  s_axis_tuser,   // has_byte[0], in_tail[1]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // fingerprint[63:0]
);

  logic       fin_valid;
  logic       fin_ready;
  fcf_final_t fin;

  fcf_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .data_byte (s_axis_tdata[7:0]),
    .has_byte  (s_axis_tuser[0]),
    .in_tail   (s_axis_tuser[1]),
    .last      (s_axis_tlast),
    .file_size (s_axis_tdata[55:8]),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  fcf_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  `ASSERT_NEXT(a_fin_holds, clk, rst, fin_valid && !fin_ready, fin_valid)
  `ASSERT_SAME(a_mix_free, clk, rst, !m_axis_tvalid, fin_ready)
  `ASSERT_SAME(a_in_free, clk, rst, !fin_valid, s_axis_tready)

endmodule

`default_nettype wire
